@@ hdl/bms_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Burgers MUSCL sweep.
`timescale 1ns / 1ps
package bms_pkg;

    localparam logic [23:0] DT_RESET = 24'd52429;
    localparam logic REG_DT_OVER_DX = 1'b0;
    localparam logic signed [23:0] V_MAX = 24'sd8388607;
    localparam logic signed [23:0] V_MIN = -24'sd8388608;
    localparam logic signed [33:0] Q_ONE = 34'sd65536;

    typedef struct packed {
        logic signed [23:0] cell_value;
        logic               is_first;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] new_value;
        logic               sweep_done;
        logic [22:0]        max_magnitude;
    } out_item_t;

    // Datapath micro-steps of one cell update, in issue order.
    typedef enum logic [3:0] {
        OP_C1, OP_C2, OP_C3, OP_RF1, OP_LF2, OP_RF2, OP_LF3,
        OP_AA, OP_BB, OP_FD1, OP_FD2, OP_NV
    } op_t;

    typedef struct packed {
        logic       accept;
        logic       restart;
        logic [1:0] start_off;
        logic       shift;
        logic       run;
        op_t        op;
        logic       load;
        logic       done;
    } cmd_t;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'(V_MAX))
            r = V_MAX;
        else if (v < 64'(V_MIN))
            r = V_MIN;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic [26:0] mag27(input logic signed [26:0] v);
        logic [26:0] r;
        r = (v < 0) ? 27'(-v) : 27'(v);
        return r;
    endfunction

    // Limited slope of the middle cell in Q.17.
    function automatic logic signed [26:0] lim_slope(input logic signed [23:0] l,
                                                     input logic signed [23:0] m,
                                                     input logic signed [23:0] r);
        logic signed [26:0] fw;
        logic signed [26:0] bw;
        logic signed [26:0] ce;
        logic signed [26:0] d1;
        logic signed [26:0] res;
        fw = (27'(r) - 27'(m)) <<< 1;
        bw = (27'(m) - 27'(l)) <<< 1;
        ce = 27'(r) - 27'(l);
        res = '0;
        if ((fw > 0 && bw > 0) || (fw < 0 && bw < 0))
        begin
            d1 = (mag27(fw) < mag27(bw)) ? fw : bw;
            res = (mag27(ce) < mag27(d1)) ? ce : d1;
        end
        return res;
    endfunction

    // Exact Riemann solution of Burgers' equation: the state at one interface.
    function automatic logic signed [23:0] riemann(input logic signed [23:0] ul,
                                                   input logic signed [23:0] ur);
        logic signed [24:0] s;
        logic signed [23:0] res;
        s = 25'(ul) + 25'(ur);
        res = '0;
        if (ul > ur)
        begin
            if (s >= -25'sd1 && s <= 25'sd1)
                res = '0;
            else
                res = (s > 0) ? ul : ur;
        end
        else if (ul > 0)
            res = ul;
        else if (ur < 0)
            res = ur;
        return res;
    endfunction

endpackage

@@ hdl/bms_datapath.sv @@
// Datapath: cell window, shared multiplier, face states, flux and output register.
`timescale 1ns / 1ps
module bms_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bms_pkg::cmd_t       cmd,
    input  bms_pkg::in_item_t   in_data,
    input  logic [23:0]         dt,
    output bms_pkg::out_item_t  out_data
);

    logic signed [23:0] win_reg [4];
    logic signed [23:0] a_reg [5];
    logic signed [23:0] x_reg;
    logic signed [26:0] d_reg [3];
    logic signed [32:0] c1_reg, c2_reg, c3_reg;
    logic signed [23:0] rf1_reg, lf2_reg, rf2_reg, lf3_reg;
    logic signed [60:0] prod_reg;
    logic signed [60:0] aa_reg;
    logic signed [31:0] fd_reg;
    logic signed [23:0] nv_reg;
    logic [22:0]        rm_reg;
    logic [22:0]        rm_next;
    bms_pkg::out_item_t out_reg;

    logic signed [23:0] x;
    logic signed [23:0] w [4];
    logic signed [23:0] a7 [7];
    logic signed [33:0] ma;
    logic signed [26:0] mb;
    logic signed [60:0] prod_r16;
    logic signed [60:0] prod_r18;
    logic signed [61:0] diff;
    logic signed [61:0] diff_r17;
    logic signed [23:0] ra, rb;
    logic [22:0]        nv_mag;

    assign x = in_data.cell_value;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            w[i] = cmd.restart ? x : win_reg[i];
        for (int i = 0; i < 4; i++)
            a7[i] = w[i];
        for (int i = 4; i < 7; i++)
            a7[i] = x;
    end

    assign ra = bms_pkg::riemann(rf1_reg, lf2_reg);
    assign rb = bms_pkg::riemann(rf2_reg, lf3_reg);

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            bms_pkg::OP_C1:
            begin
                ma = 34'(a_reg[1]);
                mb = {3'b000, dt};
            end
            bms_pkg::OP_C2:
            begin
                ma = 34'(a_reg[2]);
                mb = {3'b000, dt};
            end
            bms_pkg::OP_C3:
            begin
                ma = 34'(a_reg[3]);
                mb = {3'b000, dt};
            end
            bms_pkg::OP_RF1:
            begin
                ma = bms_pkg::Q_ONE - 34'(c1_reg);
                mb = d_reg[0];
            end
            bms_pkg::OP_LF2:
            begin
                ma = bms_pkg::Q_ONE + 34'(c2_reg);
                mb = d_reg[1];
            end
            bms_pkg::OP_RF2:
            begin
                ma = bms_pkg::Q_ONE - 34'(c2_reg);
                mb = d_reg[1];
            end
            bms_pkg::OP_LF3:
            begin
                ma = bms_pkg::Q_ONE + 34'(c3_reg);
                mb = d_reg[2];
            end
            bms_pkg::OP_AA:
            begin
                ma = 34'(ra);
                mb = 27'(ra);
            end
            bms_pkg::OP_BB:
            begin
                ma = 34'(rb);
                mb = 27'(rb);
            end
            bms_pkg::OP_FD2:
            begin
                ma = 34'(fd_reg);
                mb = {3'b000, dt};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Round to nearest, ties up: add half, then arithmetic shift.
    assign prod_r16 = (prod_reg + 61'sd32768) >>> 16;
    assign prod_r18 = (prod_reg + 61'sd131072) >>> 18;
    assign diff     = 62'(aa_reg) - 62'(prod_reg);
    assign diff_r17 = (diff + 62'sd65536) >>> 17;

    always_comb
    begin
        if (nv_reg == bms_pkg::V_MIN)
            nv_mag = 23'(bms_pkg::V_MAX);
        else if (nv_reg < 0)
            nv_mag = 23'(-nv_reg);
        else
            nv_mag = 23'(nv_reg);
        rm_next = (nv_mag > rm_reg) ? nv_mag : rm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rm_reg <= '0;
        end
        else if (cmd.accept && cmd.restart)
        begin
            rm_reg <= '0;
        end
        else if (cmd.load)
        begin
            rm_reg <= rm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int i = 0; i < 3; i++)
                win_reg[i] <= w[i + 1];
            win_reg[3] <= x;
            x_reg <= x;
            for (int i = 0; i < 5; i++)
            begin
                case (cmd.start_off)
                    2'd0:    a_reg[i] <= a7[i];
                    2'd1:    a_reg[i] <= a7[i + 1];
                    default: a_reg[i] <= a7[i + 2];
                endcase
            end
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < 4; i++)
                a_reg[i] <= a_reg[i + 1];
            a_reg[4] <= x_reg;
        end

        if (cmd.run)
        begin
            prod_reg <= ma * mb;
            case (cmd.op)
                bms_pkg::OP_C1:
                begin
                    d_reg[0] <= bms_pkg::lim_slope(a_reg[0], a_reg[1], a_reg[2]);
                    d_reg[1] <= bms_pkg::lim_slope(a_reg[1], a_reg[2], a_reg[3]);
                    d_reg[2] <= bms_pkg::lim_slope(a_reg[2], a_reg[3], a_reg[4]);
                end
                bms_pkg::OP_C2:  c1_reg <= prod_r16[32:0];
                bms_pkg::OP_C3:  c2_reg <= prod_r16[32:0];
                bms_pkg::OP_RF1: c3_reg <= prod_r16[32:0];
                bms_pkg::OP_LF2:
                    rf1_reg <= bms_pkg::sat24(64'(a_reg[1]) + 64'(prod_r18));
                bms_pkg::OP_RF2:
                    lf2_reg <= bms_pkg::sat24(64'(a_reg[2]) - 64'(prod_r18));
                bms_pkg::OP_LF3:
                    rf2_reg <= bms_pkg::sat24(64'(a_reg[2]) + 64'(prod_r18));
                bms_pkg::OP_AA:
                    lf3_reg <= bms_pkg::sat24(64'(a_reg[3]) - 64'(prod_r18));
                bms_pkg::OP_BB:  aa_reg <= prod_reg;
                bms_pkg::OP_FD1: fd_reg <= diff_r17[31:0];
                bms_pkg::OP_NV:
                    nv_reg <= bms_pkg::sat24(64'(a_reg[2]) + 64'(prod_r16));
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            out_reg.new_value     <= nv_reg;
            out_reg.sweep_done    <= cmd.done;
            out_reg.max_magnitude <= rm_next;
        end
    end

    assign out_data = out_reg;

endmodule

@@ hdl/bms_ctrl.sv @@
// Controller: sweep bookkeeping, result jobs, micro-step sequencing and output valid.
`timescale 1ns / 1ps
module bms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           is_first,
    input  logic           is_last,
    output logic           out_valid,
    input  logic           out_ready,
    output bms_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      cs_reg, cs_next;
    logic [2:0]      mask_reg, mask_next;
    bms_pkg::op_t    op_reg, op_next;
    logic            out_valid_reg, out_valid_next;

    logic            accept;
    logic            restart;
    logic [1:0]      cs_eff;
    logic [2:0]      new_mask;
    logic [2:0]      rest_mask;
    logic            slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign restart   = is_first || (cs_reg == 2'd0);
    assign cs_eff    = restart ? 2'd0 : cs_reg;
    assign new_mask  = {is_last, is_last && (cs_eff >= 2'd1), cs_eff >= 2'd2};
    assign rest_mask = mask_reg & (mask_reg - 3'd1);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cs_next        = cs_reg;
        mask_next      = mask_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd           = '0;
        cmd.restart   = restart;
        cmd.op        = op_reg;
        cmd.done      = (mask_reg == 3'b100);
        cmd.start_off = new_mask[0] ? 2'd0 : (new_mask[1] ? 2'd1 : 2'd2);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    if (is_last)
                        cs_next = 2'd0;
                    else if (cs_eff < 2'd2)
                        cs_next = cs_eff + 2'd1;
                    else
                        cs_next = 2'd2;
                    mask_next = new_mask;
                    op_next   = bms_pkg::OP_C1;
                    if (new_mask != 3'b000)
                        state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.run = 1'b1;
                if (op_reg == bms_pkg::OP_NV)
                    state_next = S_HOLD;
                else
                    op_next = bms_pkg::op_t'(op_reg + 4'd1);
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    mask_next      = rest_mask;
                    if (rest_mask != 3'b000)
                    begin
                        // next job uses the window one cell further on
                        cmd.shift  = 1'b1;
                        op_next    = bms_pkg::OP_C1;
                        state_next = S_CALC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cs_reg        <= 2'd0;
            mask_reg      <= 3'b000;
            op_reg        <= bms_pkg::OP_C1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cs_reg        <= cs_next;
            mask_reg      <= mask_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && slot_free) |=> out_valid_reg)
        else $error("result load did not raise out_valid");
    a_busy_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (mask_reg != 3'b000))
        else $error("busy with no pending job");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> (cs_reg == 2'd0))
        else $error("last cell did not end the sweep");
    a_calc_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> !cmd.load && !cmd.accept)
        else $error("transfer during calculation");
`endif

endmodule

@@ hdl/burgers_muscl_sweep_top.sv @@
// Top level: APB register, controller and datapath of the Burgers MUSCL sweep.
// Each accepted cell yields 0 to 3 results; each result takes 12 datapath
// micro-steps and one output load, which waits for a free output slot.
// An item with results holds the input (in_ready low) until its last result
// is loaded into the output register. The output register lets the
// next cell be taken while the last result waits.
// Reset (rst_n low, async) clears control state and sets dt_over_dx to 52429.
`timescale 1ns / 1ps
module burgers_muscl_sweep_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bms_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bms_pkg::out_item_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [23:0]   dt_reg;
    bms_pkg::cmd_t cmd;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dt_reg <= bms_pkg::DT_RESET;
        else if (psel && penable && pwrite && paddr[2] == bms_pkg::REG_DT_OVER_DX)
            dt_reg <= pwdata[23:0];
    end

    assign prdata = (paddr[2] == bms_pkg::REG_DT_OVER_DX) ? {8'h00, dt_reg} : 32'h0;

    bms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .is_first  (in_data.is_first),
        .is_last   (in_data.is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bms_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .dt       (dt_reg),
        .out_data (out_data)
    );

endmodule
